// ===== rtl/bfs_adjacency_matrix_order_unit_assert.svh =====
// assertion macros for the breadth-first search unit
// each macro samples on clk and is disabled while rst_n is low
`ifndef BFS_ADJACENCY_MATRIX_ORDER_UNIT_ASSERT_SVH
`define BFS_ADJACENCY_MATRIX_ORDER_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define BFSAM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BFSAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFSAM_ASSERT_SAME(label, ante, cons, msg)
`define BFSAM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/bfsam_pkg.sv =====
`default_nettype none

package bfsam_pkg;

  // graph size limits
  localparam int VTX_MAX = 64;
  localparam int VIDX_W  = $clog2(VTX_MAX);
  localparam int VNUM_W  = 7;

  // vertex count after reset
  localparam logic [VNUM_W-1:0] VCOUNT_RESET = VNUM_W'(VTX_MAX);

  // operation codes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // input transaction
  typedef struct packed {
    logic              operation;
    logic [VNUM_W-1:0] src_vertex;
    logic [VNUM_W-1:0] dst_vertex;
  } bfsam_in_t;

  // result transaction
  typedef struct packed {
    logic [VNUM_W-1:0] visited_vertex;
    logic              last;
  } bfsam_out_t;

  // adjacency memory request
  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [VIDX_W-1:0]  addr;
    logic [VTX_MAX-1:0] wdata;
  } bfsam_adj_req_t;

  // queue control
  typedef struct packed {
    logic              init;
    logic              push;
    logic              pop;
    logic [VIDX_W-1:0] push_data;
  } bfsam_q_ctl_t;

  // queue status
  typedef struct packed {
    logic empty;
    logic full;
  } bfsam_q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bfsam_adj_mem.sv =====
`default_nettype none

module bfsam_adj_mem
  import bfsam_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bfsam_adj_req_t     req,
  output logic      [VTX_MAX-1:0] row
);

  logic [VTX_MAX-1:0] mem [VTX_MAX];
  logic [VTX_MAX-1:0] row_valid_r;
  logic [VTX_MAX-1:0] rdata_r;
  logic               rvalid_r;

  // row storage, registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

  // per-row written marks, a row never written reads as no edges
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rvalid_r    <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvalid_r <= row_valid_r[req.addr];
      end
    end
  end

  assign row = rvalid_r ? rdata_r : '0;

endmodule

`default_nettype wire

// ===== rtl/bfsam_queue.sv =====
`default_nettype none

module bfsam_queue
  import bfsam_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bfsam_q_ctl_t      ctl,
  output bfsam_q_stat_t          stat,
  output logic      [VIDX_W-1:0] rdata
);

  logic [VIDX_W-1:0] mem [VTX_MAX];
  logic [VIDX_W:0]   head_r, head_nxt;
  logic [VIDX_W:0]   tail_r, tail_nxt;
  logic [VIDX_W-1:0] rdata_r;

  // pointer update
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctl.init) begin
      head_nxt = '0;
      tail_nxt = (VIDX_W+1)'(1);
    end else begin
      if (ctl.push) begin
        tail_nxt = tail_r + (VIDX_W+1)'(1);
      end
      if (ctl.pop) begin
        head_nxt = head_r + (VIDX_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // entry storage, start vertex seeded on init
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      mem[0] <= '0;
    end else if (ctl.push) begin
      mem[tail_r[VIDX_W-1:0]] <= ctl.push_data;
    end
    if (ctl.pop) begin
      rdata_r <= mem[head_r[VIDX_W-1:0]];
    end
  end

  assign rdata      = rdata_r;
  assign stat.empty = (head_r == tail_r);
  assign stat.full  = tail_r[VIDX_W];

endmodule

`default_nettype wire

// ===== rtl/bfs_adjacency_matrix_order_unit.sv =====
// Breadth-first search over an undirected graph of up to 64 vertices held as
// an adjacency bit matrix. An edge transaction sets both directions of the
// edge and keeps busy high through one read and one write per row; an
// edge with an endpoint of 0 or above the vertex count is dropped and busy
// stays low. A run transaction searches from vertex 1; for every visited
// vertex it reads the queue, reads the row, checks one column per cycle
// across the first N columns of that row, where N is the vertex count in
// use, and emits one result. Results appear with out_valid for exactly one
// cycle each and cannot be held off, so the receiver must take every one;
// the final vertex of a run carries last. The matrix is empty after reset
// with no clearing delay; edges accumulate until reset. Write cfg_wdata
// (vertex count, 0 acts as 1, above 64 as 64) only while busy is low.

`default_nettype none

`include "bfs_adjacency_matrix_order_unit_assert.svh"

module bfs_adjacency_matrix_order_unit
  import bfsam_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire bfsam_in_t         in_item,
  output logic                   out_valid,
  output bfsam_out_t             out_item,
  input  wire logic              cfg_we,
  input  wire logic [VNUM_W-1:0] cfg_wdata
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_E_RD_S = 10'b00_0000_0010,
    S_E_WR_S = 10'b00_0000_0100,
    S_E_RD_D = 10'b00_0000_1000,
    S_E_WR_D = 10'b00_0001_0000,
    S_R_INIT = 10'b00_0010_0000,
    S_R_POP  = 10'b00_0100_0000,
    S_R_ROW  = 10'b00_1000_0000,
    S_R_SCAN = 10'b01_0000_0000,
    S_R_EMIT = 10'b10_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [VNUM_W-1:0]  vcount_r;
  logic [VIDX_W-1:0]  src_r, src_nxt;
  logic [VIDX_W-1:0]  dst_r, dst_nxt;
  logic [VIDX_W-1:0]  vtx_r, vtx_nxt;
  logic [VIDX_W-1:0]  col_r, col_nxt;
  logic [VTX_MAX-1:0] disc_r, disc_nxt;

  logic [VNUM_W-1:0]  n_act;
  logic [VNUM_W-1:0]  n_m1;
  logic [VIDX_W-1:0]  col_last;
  logic [VNUM_W-1:0]  src_m1;
  logic [VNUM_W-1:0]  dst_m1;
  logic               edge_ok;
  logic               run_start;

  bfsam_adj_req_t     adj_req;
  logic [VTX_MAX-1:0] adj_row;
  bfsam_q_ctl_t       q_ctl;
  bfsam_q_stat_t      q_stat;
  logic [VIDX_W-1:0]  q_rdata;

  // vertex count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  // count in use, saturated to 1..VTX_MAX
  always_comb begin
    if (vcount_r == '0) begin
      n_act = VNUM_W'(1);
    end else if (vcount_r > VNUM_W'(VTX_MAX)) begin
      n_act = VNUM_W'(VTX_MAX);
    end else begin
      n_act = vcount_r;
    end
  end

  assign n_m1     = n_act - VNUM_W'(1);
  assign col_last = n_m1[VIDX_W-1:0];

  // edge endpoint check
  assign src_m1  = in_item.src_vertex - VNUM_W'(1);
  assign dst_m1  = in_item.dst_vertex - VNUM_W'(1);
  assign edge_ok = (in_item.src_vertex != '0) && (in_item.dst_vertex != '0) &&
                   (in_item.src_vertex <= n_act) && (in_item.dst_vertex <= n_act);

  // run transaction accepted
  assign run_start = start && !busy && (in_item.operation == OP_RUN);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    vtx_nxt   = vtx_r;
    col_nxt   = col_r;
    disc_nxt  = disc_r;
    adj_req   = '0;
    q_ctl     = '0;
    out_valid = 1'b0;
    out_item  = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.operation == OP_RUN) begin
            state_nxt = S_R_INIT;
          end else if (edge_ok) begin
            src_nxt   = src_m1[VIDX_W-1:0];
            dst_nxt   = dst_m1[VIDX_W-1:0];
            state_nxt = S_E_RD_S;
          end
        end
      end
      S_E_RD_S: begin
        adj_req.rd_en = 1'b1;
        adj_req.addr  = src_r;
        state_nxt     = S_E_WR_S;
      end
      S_E_WR_S: begin
        adj_req.wr_en = 1'b1;
        adj_req.addr  = src_r;
        adj_req.wdata = adj_row | (VTX_MAX'(1) << dst_r);
        state_nxt     = S_E_RD_D;
      end
      S_E_RD_D: begin
        adj_req.rd_en = 1'b1;
        adj_req.addr  = dst_r;
        state_nxt     = S_E_WR_D;
      end
      S_E_WR_D: begin
        adj_req.wr_en = 1'b1;
        adj_req.addr  = dst_r;
        adj_req.wdata = adj_row | (VTX_MAX'(1) << src_r);
        state_nxt     = S_IDLE;
      end
      S_R_INIT: begin
        q_ctl.init = 1'b1;
        disc_nxt   = VTX_MAX'(1);
        state_nxt  = S_R_POP;
      end
      S_R_POP: begin
        q_ctl.pop = 1'b1;
        state_nxt = S_R_ROW;
      end
      S_R_ROW: begin
        vtx_nxt       = q_rdata;
        adj_req.rd_en = 1'b1;
        adj_req.addr  = q_rdata;
        col_nxt       = '0;
        state_nxt     = S_R_SCAN;
      end
      S_R_SCAN: begin
        // one column per cycle: enqueue undiscovered neighbours
        if (adj_row[col_r] && !disc_r[col_r] && !q_stat.full) begin
          disc_nxt[col_r] = 1'b1;
          q_ctl.push      = 1'b1;
          q_ctl.push_data = col_r;
        end
        if (col_r == col_last) begin
          state_nxt = S_R_EMIT;
        end else begin
          col_nxt = col_r + VIDX_W'(1);
        end
      end
      S_R_EMIT: begin
        out_valid               = 1'b1;
        out_item.visited_vertex = VNUM_W'(vtx_r) + VNUM_W'(1);
        out_item.last           = q_stat.empty;
        state_nxt               = q_stat.empty ? S_IDLE : S_R_POP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      disc_r  <= '0;
    end else begin
      state_r <= state_nxt;
      disc_r  <= disc_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    dst_r <= dst_nxt;
    vtx_r <= vtx_nxt;
    col_r <= col_nxt;
  end

  assign busy = (state_r != S_IDLE);

  bfsam_adj_mem u_adj (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (adj_req),
    .row   (adj_row)
  );

  bfsam_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (q_ctl),
    .stat  (q_stat),
    .rdata (q_rdata)
  );

  // checks
  `BFSAM_ASSERT_SAME(a_out_while_busy, out_valid, busy, "result outside a run")
  `BFSAM_ASSERT_NEXT(a_run_goes_busy, run_start, busy, "run transaction not started")
  `BFSAM_ASSERT_NEXT(a_last_ends_run, out_valid && out_item.last, !busy, "run not ended after last")
  `BFSAM_ASSERT_NEXT(a_no_back_to_back, out_valid, !out_valid, "results in adjacent cycles")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top
  import bfsam_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 310;
  localparam int CALM_TAIL    = 50;
  localparam int QUIET_LIMIT  = 3000;
  localparam int SETTLE       = 8;

  // tracks the graph and the expected visit order of every search
  class visit_order_tracker;
    bit [63:0]   adj_rows [64];
    bit [6:0]    vcount;
    bfsam_out_t  pending_visits [$];
    int          errors;
    int          searches;
    int          visits_seen;
    int          edges_loaded;
    int          edges_dropped;
    int          count_writes;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      vcount        = VCOUNT_RESET;
      errors        = 0;
      searches      = 0;
      visits_seen   = 0;
      edges_loaded  = 0;
      edges_dropped = 0;
      count_writes  = 0;
    endfunction

    // vertex count in use, saturated to 1..64
    function int active_count();
      if (vcount == 0) return 1;
      if (vcount > VTX_MAX) return VTX_MAX;
      return int'(vcount);
    endfunction

    function void set_count(bit [6:0] value);
      vcount = value;
      count_writes++;
    endfunction

    function void report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endfunction

    // breadth-first search from vertex 1, expected results appended in order
    function void predict_search();
      bit [63:0]  seen;
      bit [5:0]   fifo [64];
      bit [5:0]   v;
      int         head;
      int         tail;
      int         n;
      bfsam_out_t r;
      n       = active_count();
      seen    = 64'd1;
      fifo[0] = '0;
      head    = 0;
      tail    = 1;
      while (head < tail) begin
        v = fifo[head];
        head++;
        for (int j = 0; j < n; j++) begin
          if (adj_rows[v][j] && !seen[j]) begin
            seen[j]    = 1'b1;
            fifo[tail] = 6'(j);
            tail++;
          end
        end
      end
      for (int k = 0; k < tail; k++) begin
        r.visited_vertex = 7'(fifo[k]) + 7'd1;
        r.last           = (k == tail - 1);
        pending_visits.push_back(r);
      end
      searches++;
    endfunction

    // called for every accepted input transaction
    function void note_item(bfsam_in_t it);
      int n;
      int s;
      int d;
      n = active_count();
      if (it.operation == OP_RUN) begin
        predict_search();
      end else begin
        s = int'(it.src_vertex);
        d = int'(it.dst_vertex);
        if (s == 0 || d == 0 || s > n || d > n) begin
          edges_dropped++;
        end else begin
          adj_rows[s-1][d-1] = 1'b1;
          adj_rows[d-1][s-1] = 1'b1;
          edges_loaded++;
        end
      end
    endfunction

    // called for every result transaction
    function void check_visit(bfsam_out_t got);
      bfsam_out_t want;
      visits_seen++;
      if (pending_visits.size() == 0) begin
        report_mismatch($sformatf("unexpected result vertex %0d last %0b",
                                  got.visited_vertex, got.last));
        return;
      end
      want = pending_visits.pop_front();
      if (got.visited_vertex !== want.visited_vertex)
        report_mismatch($sformatf("visited_vertex %0d, expected %0d",
                                  got.visited_vertex, want.visited_vertex));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b on vertex %0d, expected %0b",
                                  got.last, want.visited_vertex, want.last));
    endfunction

    function int pending();
      return pending_visits.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  bfsam_in_t         in_item;
  logic              out_valid;
  bfsam_out_t        out_item;
  logic              cfg_we;
  logic [VNUM_W-1:0] cfg_wdata;

  visit_order_tracker tracker;
  int                 quiet_cycles;
  int                 random_done;
  bit                 start_high;

  bfs_adjacency_matrix_order_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // monitor: notes transactions on both sides and watches for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker.set_count(cfg_wdata);
      if (start && !busy) tracker.note_item(in_item);
      if (out_valid === 1'b1) tracker.check_visit(out_item);
      if ((start && !busy) || out_valid === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // present one transaction and hold it until accepted
  task automatic drive_item(bfsam_in_t it);
    @(negedge clk);
    start      <= 1'b1;
    in_item    <= it;
    start_high = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // lower start, putting junk on the payload
  task automatic drop_start();
    if (start_high) begin
      @(negedge clk);
      start      <= 1'b0;
      in_item    <= bfsam_in_t'($urandom);
      start_high = 1'b0;
    end
  endtask

  task automatic idle_cycles(int k);
    drop_start();
    repeat (k) @(negedge clk);
  endtask

  // hold off until every expected result has arrived and the block is quiet
  task automatic wait_drain();
    drop_start();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_count(bit [6:0] value);
    wait_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 7'($urandom);
  endtask

  function automatic bfsam_in_t make_edge(int s, int d);
    bfsam_in_t it;
    it.operation  = OP_EDGE;
    it.src_vertex = 7'(s);
    it.dst_vertex = 7'(d);
    return it;
  endfunction

  function automatic bfsam_in_t make_run();
    bfsam_in_t it;
    it.operation  = OP_RUN;
    it.src_vertex = 7'($urandom_range(0, 127));
    it.dst_vertex = 7'($urandom_range(0, 127));
    return it;
  endfunction

  // random transaction for the current vertex count; returns 1 if it does work
  task automatic random_item(int n, output bfsam_in_t it, output bit useful);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 17) begin
      it     = make_run();
      useful = 1'b1;
    end else if (pick < 27) begin
      // noise: endpoints anywhere in the field
      it     = make_edge($urandom_range(0, 127), $urandom_range(0, 127));
      useful = it.src_vertex != 0 && it.dst_vertex != 0 &&
               it.src_vertex <= n && it.dst_vertex <= n;
    end else begin
      it     = make_edge($urandom_range(1, n), $urandom_range(1, n));
      useful = 1'b1;
    end
  endtask

  // stimulus
  initial begin
    int        phase_counts [15];
    int        phase_no;
    int        phase_len;
    int        n;
    bit [6:0]  cnt;
    bit        gaps_on;
    bit        useful;
    bfsam_in_t it;

    phase_counts = '{64, 1, 2, 127, 5, 0, 16, 65, 3, 64, 40, 8, 100, 24, 64};
    tracker      = new();
    quiet_cycles = 0;
    random_done  = 0;
    start_high   = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty graph, self loops, extreme and dropped endpoints
    drive_item(make_run());
    drive_item(make_edge(1, 1));
    drive_item(make_run());
    drive_item(make_edge(1, 64));
    drive_item(make_edge(64, 2));
    drive_item(make_edge(0, 5));
    drive_item(make_edge(5, 0));
    drive_item(make_edge(65, 3));
    drive_item(make_edge(127, 127));
    drive_item(make_edge(3, 3));
    drive_item(make_run());
    drive_item(make_edge(2, 10));
    drive_item(make_edge(1, 10));
    drive_item(make_run());
    wait_drain();
    // count lowered below loaded edges, then count of 0 acting as 1
    write_count(7'd2);
    drive_item(make_edge(2, 3));
    drive_item(make_edge(2, 1));
    drive_item(make_run());
    write_count(7'd0);
    drive_item(make_run());
    drive_item(make_edge(1, 1));
    drive_item(make_edge(1, 2));
    drive_item(make_run());

    // random phases, each under its own vertex count
    phase_no = 0;
    while (random_done < RANDOM_ITEMS) begin
      if (phase_no < 15) cnt = 7'(phase_counts[phase_no]);
      else cnt = 7'($urandom_range(0, 127));
      write_count(cnt);
      n         = tracker.active_count();
      gaps_on   = $urandom_range(0, 2) != 0;
      phase_len = $urandom_range(10, 40);
      for (int k = 0; k < phase_len && random_done < RANDOM_ITEMS; k++) begin
        random_item(n, it, useful);
        drive_item(it);
        if (useful) random_done++;
        if (random_done < RANDOM_ITEMS - CALM_TAIL) begin
          if (gaps_on && $urandom_range(0, 2) == 0)
            idle_cycles($urandom_range(1, 13));
          if ($urandom_range(0, 29) == 0) wait_drain();
        end
      end
      drive_item(make_run());
      phase_no++;
    end

    // let the last search finish
    drop_start();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2 * VTX_MAX) @(posedge clk);
    while (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("missing result vertex %0d",
                                        tracker.pending_visits.pop_front().visited_vertex));

    $display("covered %0d searches with %0d vertices emitted over %0d vertex count settings",
             tracker.searches, tracker.visits_seen, tracker.count_writes);
    $display("edges loaded %0d, edges dropped as out of range %0d, mismatches %0d",
             tracker.edges_loaded, tracker.edges_dropped, tracker.errors);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
